// ----- design/scaled_sigma_point_generator_core_defines.svh -----
// Assertion macros used by the checker file of this block.
`ifndef SCALED_SIGMA_POINT_GENERATOR_CORE_DEFINES_SVH
`define SCALED_SIGMA_POINT_GENERATOR_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSPG_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sspg assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SSPG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sspg assertion failed");

// Checked also while reset is applied.
`define SSPG_ASSERT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("sspg assertion failed");

`endif

// ----- design/sspg_pkg.sv -----
package sspg_pkg;

    localparam int MAX_DIM = 4;
    localparam int VAL_W   = 32;
    localparam int ACC_W   = 50;
    localparam int NUM_W   = 48;
    localparam int DEN_W   = 33;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] Q_ONE   = 32'sd65536;

    localparam logic [1:0] CMD_LOAD_MEAN = 2'd0;
    localparam logic [1:0] CMD_LOAD_COV  = 2'd1;
    localparam logic [1:0] CMD_COMPUTE   = 2'd2;

    localparam logic [1:0] CFG_ALPHA = 2'd0;
    localparam logic [1:0] CFG_BETA  = 2'd1;
    localparam logic [1:0] CFG_KAPPA = 2'd2;
    localparam logic [1:0] CFG_DIMS  = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_A2,
        ST_SCALE,
        ST_WM_GO,
        ST_WM_WAIT,
        ST_WC0,
        ST_WC_GO,
        ST_WC_WAIT,
        ST_AMUL,
        ST_ACC_INIT,
        ST_RD,
        ST_MUL,
        ST_SUB,
        ST_SAT,
        ST_PIVOT,
        ST_SQRT_WAIT,
        ST_DIVL_WAIT,
        ST_CHECK,
        ST_EMIT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_A2,
        OP_SCALE,
        OP_WM_GO,
        OP_WM_WR,
        OP_WC0,
        OP_WC_GO,
        OP_WC_WR,
        OP_AMUL,
        OP_ACC_INIT,
        OP_RD,
        OP_MUL,
        OP_SUB,
        OP_SAT,
        OP_FAIL,
        OP_SQRT_GO,
        OP_SQRT_WR,
        OP_DIVL_GO,
        OP_DIVL_WR,
        OP_CHECK,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] i;
        logic [1:0] j;
        logic [1:0] k;
        logic [1:0] c;
        logic [3:0] p;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic       div_done;
        logic       sqrt_done;
        logic       pivot_bad;
        logic       out_free;
        logic [1:0] n_last;
    } t_stat;

    function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [63:0] v);
        logic signed [VAL_W-1:0] r;
        if (v > 64'(VAL_MAX)) begin
            r = VAL_MAX;
        end else if (v < 64'(VAL_MIN)) begin
            r = VAL_MIN;
        end else begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

    function automatic logic sat_ovf(input logic signed [63:0] v);
        return (v > 64'(VAL_MAX)) || (v < 64'(VAL_MIN));
    endfunction

endpackage

// ----- design/scaled_sigma_point_generator_core.sv -----
// Scaled sigma point generator.
// The slave stream takes one word per command: load a mean element, load a
// covariance element (lower triangle used), or compute. Loads are taken one
// per cycle and produce no output.
// A compute word starts a sequenced run: scale and weights with two divisions,
// scaling of the lower triangle at one entry per cycle, then a
// column-by-column Cholesky factorization. Each entry starts from the scaled
// value, is reduced by a read, multiply and subtract per product term, is
// saturated, then ends in a pivot square root or a division below the pivot.
// A check pass over all (2n+1)*n outputs then fixes the error flag.
// The master stream then carries (2n+1)*n words, one per cycle when not
// stalled, with tlast on the final word. The slave side is not ready while a
// compute run is in progress.
// A stalled receiver holds the output register and pauses the run; the next
// command word is taken while the final word still waits.
// Reset clears the flags, the output valid and restores the register
// defaults; the mean and covariance stores must be loaded before use.
module scaled_sigma_point_generator_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [20:0]  i_cfg_wdata,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // cmd[1:0], row_index[3:2], col_index[5:4], load_value[37:6], zero fill
    input  logic [39:0]  i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // point_index[3:0], component_index[5:4], point_value[37:6],
    // weight_mean[69:38], weight_cov[101:70], zero fill
    output logic [103:0] o_m_tdata,
    // factor_failed[0], arith_error[1]
    output logic [1:0]   o_m_tuser,
    output logic         o_m_tlast
);
    import sspg_pkg::*;

    t_cmd                    w_cmd;
    t_stat                   w_stat;
    logic [3:0]              w_point;
    logic [1:0]              w_comp;
    logic signed [VAL_W-1:0] w_val, w_wm, w_wc;
    logic                    w_fail, w_err;

    sspg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_load_cmd (i_s_tdata[1:0]),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    sspg_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_load_cmd        (i_s_tdata[1:0]),
        .i_row             (i_s_tdata[3:2]),
        .i_col             (i_s_tdata[5:4]),
        .i_value           ($signed(i_s_tdata[37:6])),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_m_tready        (i_m_tready),
        .o_m_tvalid        (o_m_tvalid),
        .o_point_index     (w_point),
        .o_component_index (w_comp),
        .o_point_value     (w_val),
        .o_weight_mean     (w_wm),
        .o_weight_cov      (w_wc),
        .o_factor_failed   (w_fail),
        .o_arith_error     (w_err),
        .o_last_result     (o_m_tlast)
    );

    assign o_m_tdata = {2'b00, w_wc, w_wm, w_val, w_comp, w_point};
    assign o_m_tuser = {w_err, w_fail};

endmodule

// ----- design/sspg_div.sv -----
module sspg_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [sspg_pkg::NUM_W-1:0] i_num,
    input  logic signed [sspg_pkg::DEN_W-1:0] i_den,
    output logic                              o_done,
    output logic signed [sspg_pkg::VAL_W-1:0] o_quo,
    output logic                              o_ovf
);
    import sspg_pkg::*;

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [5:0]         r_cnt, n_cnt;
    logic [NUM_W-1:0]   r_q, n_q;
    logic [31:0]        r_rem, n_rem;
    logic [31:0]        r_den, n_den;
    logic               r_neg, n_neg;
    logic               r_nneg, n_nneg;
    logic               r_nzero, n_nzero;
    logic               r_dzero, n_dzero;
    logic [32:0]        w_rem_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt   <= n_cnt;
        r_q     <= n_q;
        r_rem   <= n_rem;
        r_den   <= n_den;
        r_neg   <= n_neg;
        r_nneg  <= n_nneg;
        r_nzero <= n_nzero;
        r_dzero <= n_dzero;
    end

    assign w_rem_sh = {r_rem, r_q[NUM_W-1]};

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_q     = r_q;
        n_rem   = r_rem;
        n_den   = r_den;
        n_neg   = r_neg;
        n_nneg  = r_nneg;
        n_nzero = r_nzero;
        n_dzero = r_dzero;
        if (i_start) begin
            n_busy  = 1'b1;
            n_cnt   = '0;
            n_rem   = '0;
            n_q     = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
            n_den   = i_den[DEN_W-1] ? 32'(-i_den) : 32'(i_den);
            n_neg   = i_num[NUM_W-1] ^ i_den[DEN_W-1];
            n_nneg  = i_num[NUM_W-1];
            n_nzero = (i_num == '0);
            n_dzero = (i_den == '0);
        end else if (r_busy) begin
            if (w_rem_sh >= {1'b0, r_den}) begin
                n_rem = 32'(w_rem_sh - {1'b0, r_den});
                n_q   = {r_q[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = w_rem_sh[31:0];
                n_q   = {r_q[NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'(NUM_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    assign o_done = r_done;

    always_comb begin
        o_ovf = 1'b0;
        o_quo = '0;
        if (r_dzero) begin
            o_ovf = 1'b1;
            o_quo = r_nzero ? '0 : (r_nneg ? VAL_MIN : VAL_MAX);
        end else if (r_neg) begin
            if (r_q > NUM_W'(33'h1_0000_0000 >> 1)) begin
                o_ovf = 1'b1;
                o_quo = VAL_MIN;
            end else begin
                o_quo = -$signed(r_q[VAL_W-1:0]);
            end
        end else begin
            if (r_q > NUM_W'(VAL_MAX)) begin
                o_ovf = 1'b1;
                o_quo = VAL_MAX;
            end else begin
                o_quo = $signed(r_q[VAL_W-1:0]);
            end
        end
    end

endmodule

// ----- design/sspg_sqrt.sv -----
module sspg_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [47:0] i_rad,
    output logic        o_done,
    output logic [23:0] o_root
);
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [4:0]  r_cnt, n_cnt;
    logic [47:0] r_rad, n_rad;
    logic [25:0] r_rem, n_rem;
    logic [23:0] r_root, n_root;
    logic [26:0] w_rem_sh;
    logic [26:0] w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt  <= n_cnt;
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign w_rem_sh = {r_rem[24:0], r_rad[47:46]};
    assign w_trial  = {1'b0, r_root, 2'b01};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rad  = r_rad;
        n_rem  = r_rem;
        n_root = r_root;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rad  = i_rad;
            n_rem  = '0;
            n_root = '0;
        end else if (r_busy) begin
            if (w_rem_sh >= w_trial) begin
                n_rem  = 26'(w_rem_sh - w_trial);
                n_root = {r_root[22:0], 1'b1};
            end else begin
                n_rem  = w_rem_sh[25:0];
                n_root = {r_root[22:0], 1'b0};
            end
            n_rad = {r_rad[45:0], 2'b00};
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd23) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ----- design/sspg_datapath.sv -----
module sspg_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [1:0]                        i_cfg_idx,
    input  logic [20:0]                       i_cfg_wdata,
    input  logic [1:0]                        i_load_cmd,
    input  logic [1:0]                        i_row,
    input  logic [1:0]                        i_col,
    input  logic signed [sspg_pkg::VAL_W-1:0] i_value,
    input  sspg_pkg::t_cmd                    i_cmd,
    output sspg_pkg::t_stat                   o_stat,
    input  logic                              i_m_tready,
    output logic                              o_m_tvalid,
    output logic [3:0]                        o_point_index,
    output logic [1:0]                        o_component_index,
    output logic signed [sspg_pkg::VAL_W-1:0] o_point_value,
    output logic signed [sspg_pkg::VAL_W-1:0] o_weight_mean,
    output logic signed [sspg_pkg::VAL_W-1:0] o_weight_cov,
    output logic                              o_factor_failed,
    output logic                              o_arith_error,
    output logic                              o_last_result
);
    import sspg_pkg::*;

    localparam int N_ENT = MAX_DIM * MAX_DIM;

    logic [17:0]              r_alpha;
    logic [18:0]              r_beta;
    logic signed [20:0]       r_kappa;
    logic [2:0]               r_dims;

    logic signed [VAL_W-1:0]  r_mean [MAX_DIM];
    logic signed [VAL_W-1:0]  r_cov  [N_ENT];
    logic signed [VAL_W-1:0]  r_a    [N_ENT];
    logic signed [VAL_W-1:0]  r_l    [N_ENT];

    logic [19:0]              r_a2;
    logic signed [27:0]       r_scale;
    logic signed [VAL_W-1:0]  r_wm0, r_wc0, r_wc;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [VAL_W-1:0]  r_x;
    logic signed [63:0]       r_prod;
    logic                     r_fail, r_err;

    logic                     r_out_valid;
    logic [3:0]               r_o_point;
    logic [1:0]               r_o_comp;
    logic signed [VAL_W-1:0]  r_o_val, r_o_wm, r_o_wc;
    logic                     r_o_fail, r_o_err, r_o_last;

    logic [1:0]               w_n_last;
    logic [2:0]               w_n3;
    logic [3:0]               w_n4;
    logic [3:0]               w_pm1, w_pmn;
    logic                     w_p_pos, w_p_neg;
    logic [1:0]               w_prow;
    logic [3:0]               w_laddr;
    logic signed [VAL_W-1:0]  w_lrd, w_lsel;
    logic signed [VAL_W:0]    w_v;
    logic signed [VAL_W-1:0]  w_v_sat;
    logic                     w_v_ovf;
    logic [35:0]              w_a2_prod;
    logic signed [21:0]       w_nk;
    logic signed [42:0]       w_scale_prod;
    logic signed [59:0]       w_amul;
    logic signed [63:0]       w_amul_sh;
    logic signed [27:0]       w_lambda;
    logic signed [34:0]       w_wc0_sum;
    logic signed [VAL_W-1:0]  w_acc_sat;
    logic                     w_out_free;

    logic                     w_div_start;
    logic signed [NUM_W-1:0]  w_div_num;
    logic signed [DEN_W-1:0]  w_div_den;
    logic                     w_div_done, w_div_ovf;
    logic signed [VAL_W-1:0]  w_div_quo;
    logic                     w_sqrt_start, w_sqrt_done;
    logic [23:0]              w_sqrt_root;

    assign w_n_last = (r_dims == 3'd0) ? 2'd0 :
                      (r_dims > 3'(MAX_DIM)) ? 2'(MAX_DIM - 1) : 2'(r_dims - 3'd1);
    assign w_n3     = {1'b0, w_n_last} + 3'd1;
    assign w_n4     = {2'b00, w_n_last} + 4'd1;

    assign w_pm1   = i_cmd.p - 4'd1;
    assign w_pmn   = i_cmd.p - 4'd1 - w_n4;
    assign w_p_pos = (i_cmd.p != 4'd0) && (i_cmd.p <= w_n4);
    assign w_p_neg = (i_cmd.p > w_n4);
    assign w_prow  = w_p_pos ? w_pm1[1:0] : w_pmn[1:0];

    always_comb begin
        unique case (i_cmd.op)
            OP_RD:      w_laddr = {i_cmd.i, i_cmd.k};
            OP_MUL:     w_laddr = {i_cmd.j, i_cmd.k};
            OP_DIVL_GO: w_laddr = {i_cmd.j, i_cmd.j};
            default:    w_laddr = {w_prow, i_cmd.c};
        endcase
    end
    assign w_lrd = r_l[w_laddr];

    always_comb begin
        if (r_fail) begin
            w_lsel = (w_prow == i_cmd.c) ? Q_ONE : '0;
        end else begin
            w_lsel = (i_cmd.c <= w_prow) ? w_lrd : '0;
        end
        if (w_p_pos) begin
            w_v = (VAL_W+1)'(r_mean[i_cmd.c]) + (VAL_W+1)'(w_lsel);
        end else if (w_p_neg) begin
            w_v = (VAL_W+1)'(r_mean[i_cmd.c]) - (VAL_W+1)'(w_lsel);
        end else begin
            w_v = (VAL_W+1)'(r_mean[i_cmd.c]);
        end
    end
    assign w_v_sat = sat_val(64'(w_v));
    assign w_v_ovf = sat_ovf(64'(w_v));

    assign w_a2_prod    = 36'(r_alpha) * 36'(r_alpha);
    assign w_nk         = $signed(22'({1'b0, w_n3, 16'b0})) + 22'(r_kappa);
    assign w_scale_prod = $signed({22'b0, r_a2}) * 43'(w_nk);
    assign w_amul       = 60'(r_scale) * 60'(r_cov[{i_cmd.i, i_cmd.j}]);
    assign w_amul_sh    = 64'(w_amul >>> 16);
    assign w_lambda     = r_scale - $signed(28'({w_n3, 16'b0}));
    assign w_wc0_sum    = 35'(r_wm0) + 35'(Q_ONE) - $signed(35'({1'b0, r_a2}))
                          + $signed(35'({1'b0, r_beta}));
    assign w_acc_sat    = sat_val(64'(r_acc));
    assign w_out_free   = !r_out_valid || i_m_tready;

    assign w_div_start = (i_cmd.op == OP_WM_GO) || (i_cmd.op == OP_WC_GO) ||
                         (i_cmd.op == OP_DIVL_GO);
    always_comb begin
        unique case (i_cmd.op)
            OP_WM_GO: begin
                w_div_num = $signed({16'(w_lambda >>> 12), w_lambda[11:0], 20'b0}) >>> 4;
                w_div_den = DEN_W'(r_scale);
            end
            OP_WC_GO: begin
                w_div_num = NUM_W'(64'sd2147483648);
                w_div_den = DEN_W'(r_scale);
            end
            default: begin
                w_div_num = $signed({r_acc[VAL_W-1:0], 16'b0});
                w_div_den = DEN_W'(w_lrd);
            end
        endcase
    end

    assign w_sqrt_start = (i_cmd.op == OP_SQRT_GO);

    sspg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo),
        .o_ovf   (w_div_ovf)
    );

    sspg_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sqrt_start),
        .i_rad   ({r_acc[VAL_W-1:0], 16'b0}),
        .o_done  (w_sqrt_done),
        .o_root  (w_sqrt_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= 18'd6554;
            r_beta  <= 19'd131072;
            r_kappa <= '0;
            r_dims  <= 3'd4;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ALPHA: r_alpha <= i_cfg_wdata[17:0];
                CFG_BETA:  r_beta  <= i_cfg_wdata[18:0];
                CFG_KAPPA: r_kappa <= $signed(i_cfg_wdata);
                CFG_DIMS:  r_dims  <= i_cfg_wdata[2:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) begin
            if (i_load_cmd == CMD_LOAD_MEAN) begin
                r_mean[i_row] <= i_value;
            end else begin
                r_cov[{i_row, i_col}] <= i_value;
            end
        end
        if (i_cmd.op == OP_AMUL) begin
            r_a[{i_cmd.i, i_cmd.j}] <= sat_val(w_amul_sh);
        end
        if (i_cmd.op == OP_SQRT_WR && w_sqrt_done) begin
            r_l[{i_cmd.j, i_cmd.j}] <= $signed({8'b0, w_sqrt_root});
        end
        if (i_cmd.op == OP_DIVL_WR && w_div_done) begin
            r_l[{i_cmd.i, i_cmd.j}] <= w_div_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_A2:       r_a2 <= w_a2_prod[35:16];
            OP_SCALE:    r_scale <= 28'(w_scale_prod >>> 16);
            OP_WM_WR:    if (w_div_done) r_wm0 <= w_div_quo;
            OP_WC0:      r_wc0 <= sat_val(64'(w_wc0_sum));
            OP_WC_WR:    if (w_div_done) r_wc <= w_div_quo;
            OP_ACC_INIT: r_acc <= ACC_W'(r_a[{i_cmd.i, i_cmd.j}]);
            OP_RD:       r_x <= w_lrd;
            OP_MUL:      r_prod <= 64'(r_x) * 64'(w_lrd);
            OP_SUB:      r_acc <= r_acc - ACC_W'(r_prod >>> 16);
            OP_SAT:      r_acc <= ACC_W'(w_acc_sat);
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fail <= 1'b0;
            r_err  <= 1'b0;
        end else begin
            unique case (i_cmd.op)
                OP_A2: begin
                    r_fail <= 1'b0;
                    r_err  <= 1'b0;
                end
                OP_FAIL:  r_fail <= 1'b1;
                OP_WM_WR, OP_WC_WR, OP_DIVL_WR:
                    if (w_div_done && w_div_ovf) r_err <= 1'b1;
                OP_WC0:   if (sat_ovf(64'(w_wc0_sum))) r_err <= 1'b1;
                OP_AMUL:  if (sat_ovf(w_amul_sh)) r_err <= 1'b1;
                OP_SAT:   if (sat_ovf(64'(r_acc))) r_err <= 1'b1;
                OP_CHECK: if (w_v_ovf) r_err <= 1'b1;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.op == OP_EMIT) begin
            r_o_point <= i_cmd.p;
            r_o_comp  <= i_cmd.c;
            r_o_val   <= w_v_sat;
            r_o_wm    <= (i_cmd.p == 4'd0) ? r_wm0 : r_wc;
            r_o_wc    <= (i_cmd.p == 4'd0) ? r_wc0 : r_wc;
            r_o_fail  <= r_fail;
            r_o_err   <= r_err;
            r_o_last  <= i_cmd.last;
        end
    end

    assign o_stat.div_done  = w_div_done;
    assign o_stat.sqrt_done = w_sqrt_done;
    assign o_stat.pivot_bad = (r_acc <= 0);
    assign o_stat.out_free  = w_out_free;
    assign o_stat.n_last    = w_n_last;

    assign o_m_tvalid        = r_out_valid;
    assign o_point_index     = r_o_point;
    assign o_component_index = r_o_comp;
    assign o_point_value     = r_o_val;
    assign o_weight_mean     = r_o_wm;
    assign o_weight_cov      = r_o_wc;
    assign o_factor_failed   = r_o_fail;
    assign o_arith_error     = r_o_err;
    assign o_last_result     = r_o_last;

endmodule

// ----- design/sspg_ctrl.sv -----
module sspg_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    input  logic [1:0]      i_load_cmd,
    output logic            o_s_tready,
    input  sspg_pkg::t_stat i_stat,
    output sspg_pkg::t_cmd  o_cmd
);
    import sspg_pkg::*;

    t_state     r_state, n_state;
    logic [1:0] r_i, n_i, r_j, n_j, r_k, n_k, r_c, n_c;
    logic [3:0] r_p, n_p;
    logic [3:0] w_p_last;
    logic       w_last_elem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_i <= n_i;
        r_j <= n_j;
        r_k <= n_k;
        r_c <= n_c;
        r_p <= n_p;
    end

    assign w_p_last    = {1'b0, i_stat.n_last, 1'b0} + 4'd2;
    assign w_last_elem = (r_p == w_p_last) && (r_c == i_stat.n_last);

    always_comb begin
        n_state = r_state;
        n_i = r_i;
        n_j = r_j;
        n_k = r_k;
        n_c = r_c;
        n_p = r_p;
        unique case (r_state)
            ST_IDLE: if (i_s_tvalid && i_load_cmd == CMD_COMPUTE) n_state = ST_A2;
            ST_A2:      n_state = ST_SCALE;
            ST_SCALE:   n_state = ST_WM_GO;
            ST_WM_GO:   n_state = ST_WM_WAIT;
            ST_WM_WAIT: if (i_stat.div_done) n_state = ST_WC0;
            ST_WC0:     n_state = ST_WC_GO;
            ST_WC_GO:   n_state = ST_WC_WAIT;
            ST_WC_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = ST_AMUL;
                    n_i = '0;
                    n_j = '0;
                end
            end
            ST_AMUL: begin
                if (r_j == r_i) begin
                    n_j = '0;
                    if (r_i == i_stat.n_last) begin
                        n_i = '0;
                        n_state = ST_ACC_INIT;
                    end else begin
                        n_i = r_i + 2'd1;
                    end
                end else begin
                    n_j = r_j + 2'd1;
                end
            end
            ST_ACC_INIT: begin
                n_k = '0;
                n_state = (r_j == 2'd0) ? ST_SAT : ST_RD;
            end
            ST_RD:  n_state = ST_MUL;
            ST_MUL: n_state = ST_SUB;
            ST_SUB: begin
                if (r_k == r_j - 2'd1) begin
                    n_state = ST_SAT;
                end else begin
                    n_k = r_k + 2'd1;
                    n_state = ST_RD;
                end
            end
            ST_SAT: n_state = ST_PIVOT;
            ST_PIVOT: begin
                if (r_i != r_j) begin
                    n_state = ST_DIVL_WAIT;
                end else if (i_stat.pivot_bad) begin
                    n_state = ST_CHECK;
                    n_p = '0;
                    n_c = '0;
                end else begin
                    n_state = ST_SQRT_WAIT;
                end
            end
            ST_SQRT_WAIT: begin
                if (i_stat.sqrt_done) begin
                    if (r_j == i_stat.n_last) begin
                        n_state = ST_CHECK;
                        n_p = '0;
                        n_c = '0;
                    end else begin
                        n_i = r_j + 2'd1;
                        n_state = ST_ACC_INIT;
                    end
                end
            end
            ST_DIVL_WAIT: begin
                if (i_stat.div_done) begin
                    if (r_i == i_stat.n_last) begin
                        n_j = r_j + 2'd1;
                        n_i = r_j + 2'd1;
                    end else begin
                        n_i = r_i + 2'd1;
                    end
                    n_state = ST_ACC_INIT;
                end
            end
            ST_CHECK: begin
                if (r_c == i_stat.n_last) begin
                    n_c = '0;
                    if (r_p == w_p_last) begin
                        n_p = '0;
                        n_state = ST_EMIT;
                    end else begin
                        n_p = r_p + 4'd1;
                    end
                end else begin
                    n_c = r_c + 2'd1;
                end
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    if (r_c == i_stat.n_last) begin
                        n_c = '0;
                        if (r_p == w_p_last) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_p = r_p + 4'd1;
                        end
                    end else begin
                        n_c = r_c + 2'd1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.i    = r_i;
        o_cmd.j    = r_j;
        o_cmd.k    = r_k;
        o_cmd.c    = r_c;
        o_cmd.p    = r_p;
        o_cmd.last = w_last_elem;
        o_s_tready = (r_state == ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.op = (i_s_tvalid && (i_load_cmd == CMD_LOAD_MEAN ||
                            i_load_cmd == CMD_LOAD_COV)) ? OP_LOAD : OP_NONE;
            end
            ST_A2:        o_cmd.op = OP_A2;
            ST_SCALE:     o_cmd.op = OP_SCALE;
            ST_WM_GO:     o_cmd.op = OP_WM_GO;
            ST_WM_WAIT:   o_cmd.op = OP_WM_WR;
            ST_WC0:       o_cmd.op = OP_WC0;
            ST_WC_GO:     o_cmd.op = OP_WC_GO;
            ST_WC_WAIT:   o_cmd.op = OP_WC_WR;
            ST_AMUL:      o_cmd.op = OP_AMUL;
            ST_ACC_INIT:  o_cmd.op = OP_ACC_INIT;
            ST_RD:        o_cmd.op = OP_RD;
            ST_MUL:       o_cmd.op = OP_MUL;
            ST_SUB:       o_cmd.op = OP_SUB;
            ST_SAT:       o_cmd.op = OP_SAT;
            ST_PIVOT: begin
                if (r_i != r_j) begin
                    o_cmd.op = OP_DIVL_GO;
                end else if (i_stat.pivot_bad) begin
                    o_cmd.op = OP_FAIL;
                end else begin
                    o_cmd.op = OP_SQRT_GO;
                end
            end
            ST_SQRT_WAIT: o_cmd.op = OP_SQRT_WR;
            ST_DIVL_WAIT: o_cmd.op = OP_DIVL_WR;
            ST_CHECK:     o_cmd.op = OP_CHECK;
            ST_EMIT:      o_cmd.op = i_stat.out_free ? OP_EMIT : OP_NONE;
            default:      o_cmd.op = OP_NONE;
        endcase
    end

endmodule

// ----- design/sspg_checker.sv -----
`include "scaled_sigma_point_generator_core_defines.svh"

module sspg_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_s_tready,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [103:0] o_m_tdata,
    input logic [1:0]   o_m_tuser,
    input logic         o_m_tlast
);

    `SSPG_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n, !o_m_tvalid)

    `SSPG_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))

    `SSPG_ASSERT_SAME(a_busy_while_run, i_clk, i_rst_n, o_m_tvalid && !o_m_tlast, !o_s_tready)

    `SSPG_ASSERT_NEXT(a_flags_const, i_clk, i_rst_n, o_m_tvalid && i_m_tready && !o_m_tlast, $stable(o_m_tuser))

endmodule

bind scaled_sigma_point_generator_core sspg_checker u_sspg_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);
